>>> rtl/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
// No dependencies; used by the sequencer and the top level.
package i2cee_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    localparam logic CFG_DEVICE_ADDRESS    = 1'b0;
    localparam logic CFG_HALF_PERIOD_TICKS = 1'b1;

    localparam int CFG_DATA_W = 16;

    localparam logic [6:0]  DEVICE_ADDRESS_RST    = 7'd80;
    localparam logic [15:0] HALF_PERIOD_TICKS_RST = 16'd100;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] mem_address;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
    } result_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] half_period_ticks;
    } cfg_t;

endpackage

>>> rtl/i2cee_in_if.sv
// Request channel: valid/ready handshake carrying one tick item.
// Depends on i2cee_pkg for nothing but is compiled after it.
interface i2cee_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, opcode, mem_address, write_data, sda_in, input ready);
    modport sink   (input valid, opcode, mem_address, write_data, sda_in, output ready);
endinterface

>>> rtl/i2cee_out_if.sv
// Result channel: valid/ready handshake carrying the bus levels of one tick.
// Compiled after i2cee_pkg.
interface i2cee_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;

    modport source (output valid, scl_level, sda_level, busy_res, read_data, read_valid,
                    input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, read_data, read_valid,
                    output ready);
endinterface

>>> rtl/i2cee_seq.sv
// Bus step sequencer: phase state machine, tick counter and byte shifter.
// Uses i2cee_pkg types; advances one tick each time step is high.
module i2cee_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  i2cee_pkg::item_t  item,
    input  i2cee_pkg::cfg_t   cfg,
    output i2cee_pkg::result_t result
);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_S_A      = 5'd1,
        PH_S_B      = 5'd2,
        PH_DEVW_LO  = 5'd3,
        PH_DEVW_HI  = 5'd4,
        PH_ACK1_LO  = 5'd5,
        PH_ACK1_HI  = 5'd6,
        PH_MEM_LO   = 5'd7,
        PH_MEM_HI   = 5'd8,
        PH_ACK2_LO  = 5'd9,
        PH_ACK2_HI  = 5'd10,
        PH_DAT_LO   = 5'd11,
        PH_DAT_HI   = 5'd12,
        PH_ACK3_LO  = 5'd13,
        PH_ACK3_HI  = 5'd14,
        PH_RS_LO    = 5'd15,
        PH_RS_HI    = 5'd16,
        PH_RS_HOLD  = 5'd17,
        PH_DEVR_LO  = 5'd18,
        PH_DEVR_HI  = 5'd19,
        PH_ACK4_LO  = 5'd20,
        PH_ACK4_HI  = 5'd21,
        PH_RD_LO    = 5'd22,
        PH_RD_HI    = 5'd23,
        PH_NACK_LO  = 5'd24,
        PH_NACK_HI  = 5'd25,
        PH_STOP_LO  = 5'd26,
        PH_STOP_HI  = 5'd27,
        PH_STOP_END = 5'd28
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [3:0]  bit_reg, bit_next, bit_cur, bit_inc;
    logic [15:0] tick_reg, tick_next, tick_cur, period;
    logic [7:0]  shift_reg, shift_next, shift_cur;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  rcv_reg, rcv_next;
    logic        scl, sda, fixed_sda, send_ph, done, step_end;

    always_comb
    begin
        phase_cur    = phase_reg;
        bit_cur      = bit_reg;
        tick_cur     = tick_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        is_read_next = is_read_reg;
        if (phase_reg == PH_IDLE &&
            (item.opcode == i2cee_pkg::OP_WRITE || item.opcode == i2cee_pkg::OP_READ))
        begin
            addr_next    = item.mem_address;
            data_next    = item.write_data;
            is_read_next = (item.opcode == i2cee_pkg::OP_READ);
            phase_cur    = PH_S_A;
            tick_cur     = '0;
            bit_cur      = '0;
        end
    end

    // bus levels of the current phase
    always_comb
    begin
        case (phase_cur)
            PH_IDLE, PH_S_A, PH_RS_HI, PH_STOP_END:
            begin
                scl = 1'b1; fixed_sda = 1'b1;
            end
            PH_S_B, PH_RS_HOLD, PH_STOP_HI:
            begin
                scl = 1'b1; fixed_sda = 1'b0;
            end
            PH_ACK1_HI, PH_ACK2_HI, PH_ACK3_HI, PH_ACK4_HI, PH_RD_HI, PH_NACK_HI:
            begin
                scl = 1'b1; fixed_sda = 1'b1;
            end
            PH_DEVW_HI, PH_MEM_HI, PH_DAT_HI, PH_DEVR_HI:
            begin
                scl = 1'b1; fixed_sda = 1'b0;
            end
            PH_ACK1_LO, PH_ACK2_LO, PH_ACK3_LO, PH_ACK4_LO, PH_RS_LO, PH_RD_LO, PH_NACK_LO:
            begin
                scl = 1'b0; fixed_sda = 1'b1;
            end
            default:
            begin
                scl = 1'b0; fixed_sda = 1'b0;
            end
        endcase
    end

    assign send_ph = (phase_cur == PH_DEVW_LO) || (phase_cur == PH_DEVW_HI) ||
                     (phase_cur == PH_MEM_LO)  || (phase_cur == PH_MEM_HI)  ||
                     (phase_cur == PH_DAT_LO)  || (phase_cur == PH_DAT_HI)  ||
                     (phase_cur == PH_DEVR_LO) || (phase_cur == PH_DEVR_HI);
    assign sda     = send_ph ? shift_reg[7] : fixed_sda;

    // a zero half period behaves as one tick
    assign period   = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
    assign step_end = (tick_cur + 16'd1 >= period) || (tick_cur + 16'd1 == 16'd0);
    assign bit_inc  = bit_cur + 4'd1;
    assign shift_cur = shift_reg;

    always_comb
    begin
        phase_next = phase_cur;
        bit_next   = bit_cur;
        shift_next = shift_cur;
        tick_next  = tick_cur;
        rcv_next   = rcv_reg;
        done       = 1'b0;
        if (phase_cur != PH_IDLE)
        begin
            tick_next = tick_cur + 16'd1;
            if (step_end)
            begin
                tick_next = '0;
                case (phase_cur)
                    PH_S_B:
                    begin
                        phase_next = PH_DEVW_LO;
                        shift_next = {cfg.device_address, 1'b0};
                        bit_next   = '0;
                    end
                    PH_DEVW_HI, PH_MEM_HI, PH_DAT_HI, PH_DEVR_HI:
                    begin
                        shift_next = {shift_cur[6:0], 1'b0};
                        bit_next   = bit_inc;
                        if (bit_inc >= 4'd8)
                            phase_next = phase_t'(phase_cur + 5'd1);
                        else
                            phase_next = phase_t'(phase_cur - 5'd1);
                    end
                    PH_ACK1_HI:
                    begin
                        phase_next = PH_MEM_LO;
                        shift_next = addr_next;
                        bit_next   = '0;
                    end
                    PH_ACK2_HI:
                    begin
                        if (is_read_next)
                            phase_next = PH_RS_LO;
                        else
                        begin
                            phase_next = PH_DAT_LO;
                            shift_next = data_next;
                            bit_next   = '0;
                        end
                    end
                    PH_ACK3_HI, PH_NACK_HI:
                        phase_next = PH_STOP_LO;
                    PH_RS_HOLD:
                    begin
                        phase_next = PH_DEVR_LO;
                        shift_next = {cfg.device_address, 1'b1};
                        bit_next   = '0;
                    end
                    PH_ACK4_HI:
                    begin
                        phase_next = PH_RD_LO;
                        shift_next = '0;
                        bit_next   = '0;
                    end
                    PH_RD_HI:
                    begin
                        shift_next = {shift_cur[6:0], item.sda_in};
                        bit_next   = bit_inc;
                        phase_next = (bit_inc >= 4'd8) ? PH_NACK_LO : PH_RD_LO;
                    end
                    PH_STOP_END:
                    begin
                        if (is_read_next)
                        begin
                            rcv_next = shift_cur;
                            done     = 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                    default:
                        phase_next = phase_t'(phase_cur + 5'd1);
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_reg     <= '0;
            tick_reg    <= '0;
            shift_reg   <= '0;
            addr_reg    <= '0;
            data_reg    <= '0;
            is_read_reg <= 1'b0;
            rcv_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            tick_reg    <= tick_next;
            shift_reg   <= shift_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            is_read_reg <= is_read_next;
            rcv_reg     <= rcv_next;
        end
    end

    assign result.scl_level  = scl;
    assign result.sda_level  = sda;
    assign result.busy_res   = (phase_cur != PH_IDLE);
    assign result.read_data  = rcv_next;
    assign result.read_valid = done;

    a_idle_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
        !result.busy_res |-> (result.scl_level && result.sda_level))
        else $error("bus lines not released while idle");

    a_done_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        result.read_valid |-> (is_read_next && result.busy_res))
        else $error("read completion outside a read transaction");

    a_bit_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'd8)
        else $error("bit counter overran a byte");

endmodule

>>> rtl/i2c_eeprom_byte_master_core.sv
// Top level of the I2C EEPROM byte master: input stage, sequencer, result stage.
// Depends on i2cee_pkg, i2cee_in_if, i2cee_out_if and i2cee_seq.
//
// Usage: every request on in_ch is one tick of the bus timing. opcode starts a
// byte write or a random read when the master is idle and is ignored otherwise;
// sda_in is the sampled SDA line. Every request yields exactly one result on
// out_ch with the SCL and SDA levels to drive for that tick, busy_res, and
// read_data/read_valid when a read finishes. Each bus step lasts
// half_period_ticks requests (0 counts as 1).
// Each result is registered in the result stage when the sequencer steps.
// Throughput: one request per cycle while out_ch is not stalled.
// The input stage keeps taking requests while a result waits, as long as the
// result stage can drain on the same edge; a stalled out_ch fills both stages
// and then holds in_ch.ready low.
// Configuration: cfg_we/cfg_index/cfg_data write device_address (index 0) or
// half_period_ticks (index 1), to be written only while idle.
// Reset clears both stages, puts the sequencer idle with both lines high and
// loads device_address 80 and half_period_ticks 100.
module i2c_eeprom_byte_master_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    i2cee_in_if.sink                           in_ch,
    i2cee_out_if.source                        out_ch,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                in_valid_reg, in_valid_next;
    i2cee_pkg::item_t    in_item_reg;
    logic                out_valid_reg, out_valid_next;
    i2cee_pkg::result_t  out_res_reg;
    i2cee_pkg::result_t  seq_res;
    i2cee_pkg::cfg_t     cfg_reg;
    logic                step, in_take;

    assign step        = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || step;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign in_valid_next  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            cfg_reg.device_address    <= i2cee_pkg::DEVICE_ADDRESS_RST;
            cfg_reg.half_period_ticks <= i2cee_pkg::HALF_PERIOD_TICKS_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    i2cee_pkg::CFG_DEVICE_ADDRESS:
                        cfg_reg.device_address <= cfg_data[6:0];
                    i2cee_pkg::CFG_HALF_PERIOD_TICKS:
                        cfg_reg.half_period_ticks <= cfg_data;
                    default:
                        cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.opcode      <= in_ch.opcode;
            in_item_reg.mem_address <= in_ch.mem_address;
            in_item_reg.write_data  <= in_ch.write_data;
            in_item_reg.sda_in      <= in_ch.sda_in;
        end
        if (step)
            out_res_reg <= seq_res;
    end

    i2cee_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (seq_res)
    );

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.scl_level  = out_res_reg.scl_level;
    assign out_ch.sda_level  = out_res_reg.sda_level;
    assign out_ch.busy_res   = out_res_reg.busy_res;
    assign out_ch.read_data  = out_res_reg.read_data;
    assign out_ch.read_valid = out_res_reg.read_valid;

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost after a sequencer step");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with an empty result stage");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !step)
        else $error("sequencer advanced into a full result stage");

endmodule
